### rtl/core/fst_pkg.sv
// Shared types, codes and the length/conversion table of the format string tokenizer.
// Used by every module of the block; depends on nothing.
package fst_pkg;

   localparam logic [2:0] KIND_LIT  = 3'd0;
   localparam logic [2:0] KIND_DIR  = 3'd1;
   localparam logic [2:0] KIND_SPEC = 3'd2;
   localparam logic [2:0] KIND_ERR  = 3'd3;
   localparam logic [2:0] KIND_END  = 3'd4;

   localparam logic [3:0] M_LIT = 4'd0;
   localparam logic [3:0] M_BSL = 4'd1;
   localparam logic [3:0] M_DOL = 4'd2;
   localparam logic [3:0] M_PCT = 4'd3;
   localparam logic [3:0] M_FLG = 4'd4;
   localparam logic [3:0] M_WID = 4'd5;
   localparam logic [3:0] M_WOV = 4'd6;
   localparam logic [3:0] M_AFW = 4'd7;
   localparam logic [3:0] M_DOT = 4'd8;
   localparam logic [3:0] M_PRC = 4'd9;
   localparam logic [3:0] M_LEN = 4'd10;
   localparam logic [3:0] M_ERR = 4'd11;

   localparam logic [1:0] PS_NONE = 2'd0;
   localparam logic [1:0] PS_GIVEN = 2'd1;
   localparam logic [1:0] PS_STAR = 2'd2;
   localparam logic [1:0] PS_OVF = 2'd3;

   // Table codes: length prefixes below PX_UNUSED, argument classes from AC_PTR up.
   localparam logic [4:0] PX_NONE = 5'd0;
   localparam logic [4:0] PX_L = 5'd1;
   localparam logic [4:0] PX_LL = 5'd2;
   localparam logic [4:0] PX_H = 5'd3;
   localparam logic [4:0] PX_HH = 5'd4;
   localparam logic [4:0] PX_BIGL = 5'd5;
   localparam logic [4:0] PX_ZT = 5'd6;
   localparam logic [4:0] PX_J = 5'd7;
   localparam logic [4:0] PX_UNUSED = 5'd8;
   localparam logic [4:0] AC_PTR = 5'd9;
   localparam logic [4:0] AC_INT = 5'd10;
   localparam logic [4:0] AC_UINT = 5'd11;
   localparam logic [4:0] AC_ULLONG = 5'd12;
   localparam logic [4:0] AC_LONG = 5'd13;
   localparam logic [4:0] AC_ULONG = 5'd14;
   localparam logic [4:0] AC_SHORT = 5'd15;
   localparam logic [4:0] AC_USHORT = 5'd16;
   localparam logic [4:0] AC_CHAR = 5'd17;
   localparam logic [4:0] AC_UCHAR = 5'd18;
   localparam logic [4:0] AC_LLONG = 5'd19;
   localparam logic [4:0] AC_SIZET = 5'd20;
   localparam logic [4:0] AC_IMAX = 5'd21;
   localparam logic [4:0] AC_UMAX = 5'd22;
   localparam logic [4:0] AC_PDIFF = 5'd23;
   localparam logic [4:0] AC_UIPTR = 5'd24;
   localparam logic [4:0] AC_DBL = 5'd25;
   localparam logic [4:0] AC_LDBL = 5'd26;
   localparam logic [4:0] AC_NOARG = 5'd27;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  char_out;
      logic [1:0]  directive;
      logic [5:0]  flag_bits;
      logic [30:0] width;
      logic        width_from_arg;
      logic [30:0] precision;
      logic [1:0]  precision_mode;
      logic [2:0]  length_prefix;
      logic [4:0]  arg_class;
      logic        last;
   } result_type;

   // All results caused by one input byte.
   typedef struct packed {
      logic [1:0]      count;
      result_type [2:0] res;
   } bundle_type;

   function automatic result_type mk_res(input logic [2:0] kind, input logic [7:0] ch,
                                         input logic [1:0] dir);
      result_type r;
      r = '0;
      r.kind = kind;
      r.char_out = ch;
      r.directive = dir;
      return r;
   endfunction

   function automatic logic is_int_conv(input logic [7:0] c);
      return c == "d" || c == "i" || c == "o" || c == "u" || c == "x" || c == "X";
   endfunction

   function automatic logic is_flt_conv(input logic [7:0] c);
      return c == "e" || c == "f" || c == "g" || c == "a" ||
             c == "E" || c == "F" || c == "G" || c == "A";
   endfunction

   // Next table entry for a length state and a character.
   function automatic logic [4:0] len_lookup(input logic [2:0] prev, input logic [7:0] c);
      logic [4:0] r;
      r = PX_NONE;
      case (prev)
         3'd0: begin
            if (c == "d" || c == "i" || c == "c") r = AC_INT;
            else if (c == "o" || c == "u" || c == "x" || c == "X" || c == "C") r = AC_UINT;
            else if (is_flt_conv(c)) r = AC_DBL;
            else if (c == "s" || c == "S" || c == "n") r = AC_PTR;
            else if (c == "p") r = AC_UIPTR;
            else if (c == "m") r = AC_NOARG;
            else if (c == "l") r = PX_L;
            else if (c == "h") r = PX_H;
            else if (c == "L") r = PX_BIGL;
            else if (c == "z" || c == "t") r = PX_ZT;
            else if (c == "j") r = PX_J;
         end
         3'd1: begin
            if (c == "d" || c == "i") r = AC_LONG;
            else if (c == "o" || c == "u" || c == "x" || c == "X") r = AC_ULONG;
            else if (is_flt_conv(c)) r = AC_DBL;
            else if (c == "c") r = AC_UINT;
            else if (c == "s" || c == "n") r = AC_PTR;
            else if (c == "l") r = PX_LL;
         end
         3'd2: begin
            if (c == "d" || c == "i") r = AC_LLONG;
            else if (c == "o" || c == "u" || c == "x" || c == "X") r = AC_ULLONG;
            else if (c == "n") r = AC_PTR;
         end
         3'd3: begin
            if (c == "d" || c == "i") r = AC_SHORT;
            else if (c == "o" || c == "u" || c == "x" || c == "X") r = AC_USHORT;
            else if (c == "n") r = AC_PTR;
            else if (c == "h") r = PX_HH;
         end
         3'd4: begin
            if (c == "d" || c == "i") r = AC_CHAR;
            else if (c == "o" || c == "u" || c == "x" || c == "X") r = AC_UCHAR;
            else if (c == "n") r = AC_PTR;
         end
         3'd5: begin
            if (is_flt_conv(c)) r = AC_LDBL;
            else if (c == "n") r = AC_PTR;
         end
         3'd6: begin
            if (c == "d" || c == "i") r = AC_PDIFF;
            else if (c == "o" || c == "u" || c == "x" || c == "X") r = AC_SIZET;
            else if (c == "n") r = AC_PTR;
         end
         3'd7: begin
            if (c == "d" || c == "i") r = AC_IMAX;
            else if (c == "o" || c == "u" || c == "x" || c == "X") r = AC_UMAX;
            else if (c == "n") r = AC_PTR;
         end
         default: r = PX_NONE;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/fst_front.sv
// Front end of the format string tokenizer: takes one byte per beat and turns it
// into a bundle of up to three results. Depends on fst_pkg.
module fst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        char_in,
   output logic              bundle_push,
   output fst_pkg::bundle_type bundle
);
   import fst_pkg::*;

   logic [3:0]  mode_ff, mode_in;
   logic [7:0]  pend_ff, pend_in;
   logic [1:0]  pcount_ff, pcount_in;
   logic [5:0]  flag_ff, flag_in;
   logic [30:0] width_ff, width_in;
   logic        star_ff, star_in;
   logic [30:0] prec_ff, prec_in;
   logic [1:0]  pstate_ff, pstate_in;
   logic [2:0]  lstate_ff, lstate_in;

   result_type  res_c [3];
   logic [1:0]  n_c;
   logic [3:0]  m_c;
   logic        done_c;
   logic        clr_c;
   logic        digit;
   logic [34:0] wsum, psum;
   logic        wovf, povf;
   logic [4:0]  st;
   logic [7:0]  conv;
   logic [5:0]  fl;

   assign digit = char_in >= "0" && char_in <= "9";
   assign wsum = ({4'b0, width_ff} << 3) + ({4'b0, width_ff} << 1) + {31'b0, char_in[3:0]};
   assign psum = ({4'b0, prec_ff} << 3) + ({4'b0, prec_ff} << 1) + {31'b0, char_in[3:0]};
   assign wovf = |wsum[34:31];
   assign povf = |psum[34:31];
   assign st = len_lookup(lstate_ff, char_in);

   always_comb begin
      conv = char_in;
      if (lstate_ff != 3'd0 && conv[3:0] == 4'd3) conv[5] = 1'b0;
      fl = flag_ff;
      if (fl[2]) fl[1] = 1'b0;
   end

   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      pcount_in = pcount_ff;
      flag_in = flag_ff;
      width_in = width_ff;
      star_in = star_ff;
      prec_in = prec_ff;
      pstate_in = pstate_ff;
      lstate_in = lstate_ff;
      for (int i = 0; i < 3; i++) res_c[i] = '0;
      n_c = 2'd0;
      m_c = mode_ff;
      done_c = 1'b0;
      clr_c = 1'b0;

      // A byte that is scanned again as fresh literal input is marked by done_c low
      // with m_c set to M_LIT.
      case (mode_ff)
         M_LIT: m_c = M_LIT;
         M_BSL: begin
            mode_in = M_LIT;
            if (char_in == "$") begin
               res_c[n_c] = mk_res(KIND_LIT, "$", 2'd0);
               n_c = n_c + 2'd1;
               done_c = 1'b1;
            end else begin
               res_c[n_c] = mk_res(KIND_LIT, "\\", 2'd0);
               n_c = n_c + 2'd1;
               m_c = M_LIT;
            end
         end
         M_DOL: begin
            if (pcount_ff < 2'd2) begin
               if (char_in == "f" || char_in == "b" || char_in == "s" || char_in == "a") begin
                  pend_in = char_in;
                  pcount_in = 2'd2;
                  done_c = 1'b1;
               end else begin
                  pcount_in = 2'd0;
                  mode_in = M_LIT;
                  res_c[n_c] = mk_res(KIND_LIT, "$", 2'd0);
                  n_c = n_c + 2'd1;
                  m_c = M_LIT;
               end
            end else begin
               pcount_in = 2'd0;
               mode_in = M_LIT;
               done_c = 1'b1;
               if (pend_ff == "f" && char_in == "g") begin
                  res_c[n_c] = mk_res(KIND_DIR, 8'd0, 2'd0);
                  n_c = n_c + 2'd1;
               end else if (pend_ff == "b" && char_in == "g") begin
                  res_c[n_c] = mk_res(KIND_DIR, 8'd0, 2'd1);
                  n_c = n_c + 2'd1;
               end else if (pend_ff == "s" && char_in == "p") begin
                  res_c[n_c] = mk_res(KIND_DIR, 8'd0, 2'd2);
                  n_c = n_c + 2'd1;
               end else if (pend_ff == "a" && char_in == "n") begin
                  res_c[n_c] = mk_res(KIND_DIR, 8'd0, 2'd3);
                  n_c = n_c + 2'd1;
               end else begin
                  // The held letter is always a plain literal.
                  res_c[n_c] = mk_res(KIND_LIT, "$", 2'd0);
                  n_c = n_c + 2'd1;
                  res_c[n_c] = mk_res(KIND_LIT, pend_ff, 2'd0);
                  n_c = n_c + 2'd1;
                  done_c = 1'b0;
                  m_c = M_LIT;
               end
            end
         end
         M_ERR: begin
            done_c = 1'b1;
            if (char_in == 8'd0) begin
               res_c[n_c] = mk_res(KIND_END, 8'd0, 2'd0);
               n_c = n_c + 2'd1;
               mode_in = M_LIT;
            end
         end
         M_PCT, M_FLG, M_WID, M_WOV, M_AFW, M_DOT, M_PRC, M_LEN: begin
            if (m_c == M_PCT && char_in == "%") begin
               res_c[n_c] = mk_res(KIND_LIT, "%", 2'd0);
               n_c = n_c + 2'd1;
               mode_in = M_LIT;
               done_c = 1'b1;
            end else if (m_c <= M_FLG) begin
               done_c = 1'b1;
               if (char_in == "#") begin
                  flag_in[0] = 1'b1; mode_in = M_FLG;
               end else if (char_in == "0") begin
                  flag_in[1] = 1'b1; mode_in = M_FLG;
               end else if (char_in == "-") begin
                  flag_in[2] = 1'b1; mode_in = M_FLG;
               end else if (char_in == " ") begin
                  flag_in[3] = 1'b1; mode_in = M_FLG;
               end else if (char_in == "+") begin
                  flag_in[4] = 1'b1; mode_in = M_FLG;
               end else if (char_in == "'") begin
                  flag_in[5] = 1'b1; mode_in = M_FLG;
               end else if (char_in == "*") begin
                  star_in = 1'b1; mode_in = M_AFW;
               end else if (char_in >= "1" && char_in <= "9") begin
                  width_in = {27'd0, char_in[3:0]}; mode_in = M_WID;
               end else begin
                  done_c = 1'b0;
                  m_c = M_AFW;
               end
            end else if (m_c == M_WID) begin
               if (digit) begin
                  done_c = 1'b1;
                  if (wovf) mode_in = M_WOV;
                  else width_in = wsum[30:0];
               end else begin
                  m_c = M_AFW;
               end
            end else if (m_c == M_WOV) begin
               done_c = 1'b1;
               if (!digit) begin
                  res_c[n_c] = mk_res(KIND_ERR, 8'd0, 2'd0);
                  n_c = n_c + 2'd1;
                  clr_c = 1'b1;
                  if (char_in == 8'd0) begin
                     res_c[n_c] = mk_res(KIND_END, 8'd0, 2'd0);
                     n_c = n_c + 2'd1;
                     mode_in = M_LIT;
                  end else begin
                     mode_in = M_ERR;
                  end
               end
            end
            if (!done_c && m_c == M_AFW) begin
               if (char_in == ".") begin
                  pstate_in = PS_GIVEN; prec_in = '0; mode_in = M_DOT; done_c = 1'b1;
               end else begin
                  m_c = M_LEN;
               end
            end
            if (!done_c && m_c == M_DOT) begin
               if (char_in == "*") begin
                  pstate_in = PS_STAR; mode_in = M_LEN; done_c = 1'b1;
               end else begin
                  m_c = M_PRC;
               end
            end
            if (!done_c && m_c == M_PRC && digit) begin
               done_c = 1'b1;
               mode_in = M_PRC;
               if (pstate_ff == PS_GIVEN) begin
                  if (povf) begin
                     pstate_in = PS_OVF; prec_in = '0;
                  end else begin
                     prec_in = psum[30:0];
                  end
               end
            end
            if (!done_c) begin
               // Length prefix or conversion character.
               done_c = 1'b1;
               if (char_in < "A" || char_in > "z" || st == PX_NONE || st == PX_UNUSED ||
                   (st > PX_UNUSED && pstate_ff == PS_OVF &&
                    (is_int_conv(conv) || is_flt_conv(conv)))) begin
                  res_c[n_c] = mk_res(KIND_ERR, 8'd0, 2'd0);
                  n_c = n_c + 2'd1;
                  clr_c = 1'b1;
                  if (char_in == 8'd0) begin
                     res_c[n_c] = mk_res(KIND_END, 8'd0, 2'd0);
                     n_c = n_c + 2'd1;
                     mode_in = M_LIT;
                  end else begin
                     mode_in = M_ERR;
                  end
               end else if (st < PX_UNUSED) begin
                  lstate_in = st[2:0];
                  mode_in = M_LEN;
               end else begin
                  res_c[n_c] = mk_res(KIND_SPEC, conv, 2'd0);
                  res_c[n_c].flag_bits = fl;
                  res_c[n_c].width = star_ff ? '0 : width_ff;
                  res_c[n_c].width_from_arg = star_ff;
                  res_c[n_c].precision = (pstate_ff == PS_GIVEN) ? prec_ff : '0;
                  res_c[n_c].precision_mode = pstate_ff;
                  res_c[n_c].length_prefix = lstate_ff;
                  res_c[n_c].arg_class = st - AC_PTR;
                  n_c = n_c + 2'd1;
                  clr_c = 1'b1;
                  mode_in = M_LIT;
               end
            end
         end
         default: begin
            mode_in = M_LIT;
            m_c = M_LIT;
         end
      endcase

      // Fresh literal scan of the current byte.
      if (!done_c && m_c == M_LIT) begin
         if (char_in == 8'd0) begin
            res_c[n_c] = mk_res(KIND_END, 8'd0, 2'd0);
            n_c = n_c + 2'd1;
            mode_in = M_LIT;
         end else if (char_in == "%") begin
            clr_c = 1'b1;
            mode_in = M_PCT;
         end else if (char_in == "\\") begin
            mode_in = M_BSL;
         end else if (char_in == "$") begin
            pcount_in = 2'd1;
            mode_in = M_DOL;
         end else begin
            res_c[n_c] = mk_res(KIND_LIT, char_in, 2'd0);
            n_c = n_c + 2'd1;
         end
      end

      if (clr_c) begin
         flag_in = '0;
         width_in = '0;
         star_in = 1'b0;
         prec_in = '0;
         pstate_in = PS_NONE;
         lstate_in = 3'd0;
      end

      if (n_c != 2'd0) res_c[n_c - 2'd1].last = 1'b1;
   end

   always_comb begin
      bundle.count = n_c;
      bundle.res[0] = res_c[0];
      bundle.res[1] = res_c[1];
      bundle.res[2] = res_c[2];
   end

   assign bundle_push = accept && (n_c != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_LIT;
         pend_ff <= '0;
         pcount_ff <= '0;
         flag_ff <= '0;
         width_ff <= '0;
         star_ff <= 1'b0;
         prec_ff <= '0;
         pstate_ff <= PS_NONE;
         lstate_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         pcount_ff <= pcount_in;
         flag_ff <= flag_in;
         width_ff <= width_in;
         star_ff <= star_in;
         prec_ff <= prec_in;
         pstate_ff <= pstate_in;
         lstate_ff <= lstate_in;
      end
   end

endmodule

### rtl/core/fst_queue.sv
// Two-entry queue of result bundles between the front and back ends.
// Depends on fst_pkg.
module fst_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_in,
   input  fst_pkg::bundle_type data_in,
   output logic              q_full,
   input  logic              pop_in,
   output logic              q_valid,
   output fst_pkg::bundle_type head,
   output logic [1:0]        q_count
);
   import fst_pkg::*;

   bundle_type entry_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign q_full = count_ff == 2'd2;
   assign q_valid = count_ff != 2'd0;
   assign head = entry_ff[rd_ff];
   assign q_count = count_ff;
   assign do_push = push_in && !q_full;
   assign do_pop = pop_in && q_valid;

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

### rtl/core/fst_back.sv
// Back end of the format string tokenizer: holds one bundle in an output register
// and hands its results out one beat at a time. Depends on fst_pkg.
module fst_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  fst_pkg::bundle_type head,
   output logic              q_pop,
   input  logic              pop,
   output logic              empty,
   output fst_pkg::result_type result
);
   import fst_pkg::*;

   bundle_type cur_ff;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       take, at_end, load;

   assign empty = !valid_ff;
   assign result = cur_ff.res[idx_ff];
   assign take = pop && valid_ff;
   assign at_end = idx_ff == cur_ff.count - 2'd1;
   assign load = q_valid && (!valid_ff || (take && at_end));
   assign q_pop = load;

   always_comb begin
      valid_in = valid_ff;
      idx_in = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in = 2'd0;
      end else if (take) begin
         if (at_end) valid_in = 1'b0;
         else idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) cur_ff <= head;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff <= idx_in;
      end
   end

endmodule

### rtl/core/format_string_tokenizer_unit.sv
// Top level of the format string tokenizer: front end, bundle queue and back end.
// Depends on fst_pkg, fst_front, fst_queue and fst_back.
//
// The block takes a zero-terminated format string one byte per beat and gives
// literal, directive, conversion spec, error and end results.
// Input channel: a byte on req_char_in is taken at a clock edge where push is
// high and full is low. Result channel: while empty is low the oldest result
// sits on the rsp_ ports and is taken at an edge where pop is high.
// One byte gives zero to three results; rsp_last marks the final one of a byte.
// The front end handles a byte in the cycle it is taken and writes its results
// as one bundle into a two-entry queue. The back end copies a bundle into its
// output register and hands out one result per cycle while pop is high.
// A result reaches the rsp_ ports through the queue and then the output register.
// Throughput: one byte per cycle while each byte gives at most one result and pop
// stays high; in general the output port, one result per cycle, sets the rate.
// When the receiver stalls, the queue fills and full rises after two more
// bundles; bytes that give no result are taken even then until the queue
// is full. Reset empties the queue and output and returns parsing to the
// literal scan with no spec in progress.
module format_string_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_char_in,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_char_out,
   output logic [1:0]  rsp_directive,
   output logic [5:0]  rsp_flag_bits,
   output logic [30:0] rsp_width,
   output logic        rsp_width_from_arg,
   output logic [30:0] rsp_precision,
   output logic [1:0]  rsp_precision_mode,
   output logic [2:0]  rsp_length_prefix,
   output logic [4:0]  rsp_arg_class,
   output logic        rsp_last
);
   import fst_pkg::*;

   bundle_type bundle, head;
   result_type result;
   logic       accept, bundle_push, q_full, q_valid, q_pop;
   logic [1:0] q_count;

   // A byte is refused whenever the queue is full, also one that gives no result.
   assign full = q_full;
   assign accept = push && !q_full;

   fst_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_in     (req_char_in),
      .bundle_push (bundle_push),
      .bundle      (bundle)
   );

   fst_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (bundle_push),
      .data_in (bundle),
      .q_full  (q_full),
      .pop_in  (q_pop),
      .q_valid (q_valid),
      .head    (head),
      .q_count (q_count)
   );

   fst_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .head    (head),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .result  (result)
   );

   assign rsp_kind = result.kind;
   assign rsp_char_out = result.char_out;
   assign rsp_directive = result.directive;
   assign rsp_flag_bits = result.flag_bits;
   assign rsp_width = result.width;
   assign rsp_width_from_arg = result.width_from_arg;
   assign rsp_precision = result.precision;
   assign rsp_precision_mode = result.precision_mode;
   assign rsp_length_prefix = result.length_prefix;
   assign rsp_arg_class = result.arg_class;
   assign rsp_last = result.last;

   // The queue never holds more than its two entries.
   assert property (@(posedge clock) disable iff (reset) q_count != 2'd3)
      else $error("bundle queue count out of range");

   // An end result always closes the results of its byte.
   assert property (@(posedge clock) disable iff (reset)
                    (!empty && rsp_kind == KIND_END) |-> rsp_last)
      else $error("end result not marked last");

   // Only a conversion spec carries spec fields.
   assert property (@(posedge clock) disable iff (reset)
                    (!empty && rsp_kind != KIND_SPEC) |->
                    (rsp_flag_bits == 6'd0 && rsp_width == 31'd0 && rsp_arg_class == 5'd0))
      else $error("spec fields set on a non-spec result");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> empty)
      else $error("result offered right after reset");

endmodule

### verif/tb_format_string_tokenizer_unit.sv
// Self-checking testbench of the format string tokenizer: directed strings, then random
// format strings and noise, checked against an in-bench token predictor.
// Depends on fst_pkg and format_string_tokenizer_unit.
module tb_format_string_tokenizer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import fst_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_BYTES = 160;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_char_in;
   logic        empty;
   logic        pop;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_char_out;
   logic [1:0]  rsp_directive;
   logic [5:0]  rsp_flag_bits;
   logic [30:0] rsp_width;
   logic        rsp_width_from_arg;
   logic [30:0] rsp_precision;
   logic [1:0]  rsp_precision_mode;
   logic [2:0]  rsp_length_prefix;
   logic [4:0]  rsp_arg_class;
   logic        rsp_last;

   format_string_tokenizer_unit dut (.*);

   // 2 ns clock period.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Shared control of the traffic shape.
   bit idle_on = 1'b1;
   bit hold_req = 1'b0;
   int hold_cnt = 0;
   int mismatch_count = 0;
   int bytes_sent = 0;
   int idle_cycles = 0;

   // Tokens the predictor expects, oldest first.
   result_type expected_tokens[$];

   // Predictor state: a shadow of the parser.
   logic [3:0]  scan_mode;
   logic [7:0]  held_letter;
   logic [1:0]  held_count;
   logic [5:0]  spec_flags;
   logic [31:0] spec_width;
   logic        spec_width_star;
   logic [31:0] spec_prec;
   logic [1:0]  spec_prec_state;
   logic [2:0]  spec_len;

   // Tokens produced by the byte currently being predicted.
   result_type step_tokens[3];
   int step_count;

   // Bytes of a format string being assembled before it is sent.
   logic [7:0] fmt_bytes[$];

   // ------------------------------------------------------------------
   // Token predictor
   // ------------------------------------------------------------------

   task automatic add_token(input logic [2:0] kind, input logic [7:0] ch,
                            input logic [1:0] dir);
      result_type r;
      if (step_count < 3) begin
         r = '0;
         r.kind = kind;
         r.char_out = ch;
         r.directive = dir;
         step_tokens[step_count] = r;
         step_count++;
      end
   endtask

   task automatic clear_spec_state();
      spec_flags = '0;
      spec_width = '0;
      spec_width_star = 1'b0;
      spec_prec = '0;
      spec_prec_state = PS_NONE;
      spec_len = '0;
   endtask

   // A malformed spec: error token, then either the end token or skipping.
   task automatic spec_error(input logic [7:0] c);
      add_token(KIND_ERR, 8'h00, 2'd0);
      clear_spec_state();
      if (c == 8'h00) begin
         add_token(KIND_END, 8'h00, 2'd0);
         scan_mode = M_LIT;
      end else begin
         scan_mode = M_ERR;
      end
   endtask

   // Adds one decimal digit; returns 0 when the value would pass 2^31-1.
   function automatic bit add_decimal(inout logic [31:0] acc, input logic [31:0] d);
      if (acc > 32'd214748364 || d > 32'd2147483647 - 32'd10 * acc) return 1'b0;
      acc = acc * 32'd10 + d;
      return 1'b1;
   endfunction

   function automatic logic [5:0] flag_mask(input logic [7:0] c);
      case (c)
         "#":  return 6'b000001;
         "0":  return 6'b000010;
         "-":  return 6'b000100;
         " ":  return 6'b001000;
         "+":  return 6'b010000;
         "'":  return 6'b100000;
         default: return 6'b000000;
      endcase
   endfunction

   // Integer and float conversions are the ones an overflowed precision breaks.
   function automatic bit needs_precision(input logic [7:0] c);
      case (c)
         "d", "i", "o", "u", "x", "X", "e", "f", "g", "a", "E", "F", "G", "A": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Length/conversion table: a length state below PX_UNUSED, a class above it.
   function automatic logic [4:0] length_entry(input logic [2:0] prev, input logic [7:0] c);
      case (prev)
         3'd0: case (c)
            "d", "i", "c": return AC_INT;
            "o", "u", "x", "X", "C": return AC_UINT;
            "e", "f", "g", "a", "E", "F", "G", "A": return AC_DBL;
            "s", "S", "n": return AC_PTR;
            "p": return AC_UIPTR;
            "m": return AC_NOARG;
            "l": return PX_L;
            "h": return PX_H;
            "L": return PX_BIGL;
            "z", "t": return PX_ZT;
            "j": return PX_J;
            default: return PX_NONE;
         endcase
         3'd1: case (c)
            "d", "i": return AC_LONG;
            "o", "u", "x", "X": return AC_ULONG;
            "e", "f", "g", "a", "E", "F", "G", "A": return AC_DBL;
            "c": return AC_UINT;
            "s", "n": return AC_PTR;
            "l": return PX_LL;
            default: return PX_NONE;
         endcase
         3'd2: case (c)
            "d", "i": return AC_LLONG;
            "o", "u", "x", "X": return AC_ULLONG;
            "n": return AC_PTR;
            default: return PX_NONE;
         endcase
         3'd3: case (c)
            "d", "i": return AC_SHORT;
            "o", "u", "x", "X": return AC_USHORT;
            "n": return AC_PTR;
            "h": return PX_HH;
            default: return PX_NONE;
         endcase
         3'd4: case (c)
            "d", "i": return AC_CHAR;
            "o", "u", "x", "X": return AC_UCHAR;
            "n": return AC_PTR;
            default: return PX_NONE;
         endcase
         3'd5: case (c)
            "e", "f", "g", "a", "E", "F", "G", "A": return AC_LDBL;
            "n": return AC_PTR;
            default: return PX_NONE;
         endcase
         3'd6: case (c)
            "d", "i": return AC_PDIFF;
            "o", "u", "x", "X": return AC_SIZET;
            "n": return AC_PTR;
            default: return PX_NONE;
         endcase
         default: case (c)
            "d", "i": return AC_IMAX;
            "o", "u", "x", "X": return AC_UMAX;
            "n": return AC_PTR;
            default: return PX_NONE;
         endcase
      endcase
   endfunction

   task automatic plain_byte(input logic [7:0] c);
      if (c == 8'h00) begin
         add_token(KIND_END, 8'h00, 2'd0);
         scan_mode = M_LIT;
      end else if (c == "%") begin
         clear_spec_state();
         scan_mode = M_PCT;
      end else if (c == "\\") begin
         scan_mode = M_BSL;
      end else if (c == "$") begin
         held_count = 2'd1;
         scan_mode = M_DOL;
      end else begin
         add_token(KIND_LIT, c, 2'd0);
      end
   endtask

   task automatic dollar_byte(input logic [7:0] c);
      logic [7:0] s;
      if (held_count < 2) begin
         if (c == "f" || c == "b" || c == "s" || c == "a") begin
            held_letter = c;
            held_count = 2'd2;
            return;
         end
         held_count = 2'd0;
         scan_mode = M_LIT;
         add_token(KIND_LIT, "$", 2'd0);
         plain_byte(c);
         return;
      end
      s = held_letter;
      held_count = 2'd0;
      scan_mode = M_LIT;
      if (s == "f" && c == "g") add_token(KIND_DIR, 8'h00, 2'd0);
      else if (s == "b" && c == "g") add_token(KIND_DIR, 8'h00, 2'd1);
      else if (s == "s" && c == "p") add_token(KIND_DIR, 8'h00, 2'd2);
      else if (s == "a" && c == "n") add_token(KIND_DIR, 8'h00, 2'd3);
      else begin
         // No directive: the dollar goes out and both held bytes are rescanned.
         add_token(KIND_LIT, "$", 2'd0);
         plain_byte(s);
         plain_byte(c);
      end
   endtask

   task automatic conversion_byte(input logic [7:0] c);
      logic [2:0] prev;
      logic [4:0] entry;
      logic [7:0] conv;
      logic [5:0] fl;
      prev = spec_len;
      if (c < "A" || c > "z") begin
         spec_error(c);
         return;
      end
      entry = length_entry(prev, c);
      if (entry == PX_NONE || entry == PX_UNUSED) begin
         spec_error(c);
         return;
      end
      if (entry < PX_UNUSED) begin
         spec_len = entry[2:0];
         scan_mode = M_LEN;
         return;
      end
      // With a length prefix, c and s fold to upper case.
      conv = c;
      if (prev != 3'd0 && conv[3:0] == 4'd3) conv[5] = 1'b0;
      if (spec_prec_state == PS_OVF && needs_precision(conv)) begin
         spec_error(c);
         return;
      end
      fl = spec_flags;
      if (fl[2]) fl[1] = 1'b0;
      add_token(KIND_SPEC, conv, 2'd0);
      step_tokens[step_count-1].flag_bits = fl;
      step_tokens[step_count-1].width = spec_width_star ? 31'd0 : spec_width[30:0];
      step_tokens[step_count-1].width_from_arg = spec_width_star;
      step_tokens[step_count-1].precision =
         (spec_prec_state == PS_GIVEN) ? spec_prec[30:0] : 31'd0;
      step_tokens[step_count-1].precision_mode = spec_prec_state;
      step_tokens[step_count-1].length_prefix = prev;
      step_tokens[step_count-1].arg_class = entry - AC_PTR;
      clear_spec_state();
      scan_mode = M_LIT;
   endtask

   task automatic spec_char(input logic [7:0] c);
      logic [3:0] m;
      bit is_digit;
      m = scan_mode;
      is_digit = (c >= "0" && c <= "9");
      if (m == M_PCT && c == "%") begin
         add_token(KIND_LIT, "%", 2'd0);
         scan_mode = M_LIT;
         return;
      end
      if (m <= M_FLG) begin
         if (flag_mask(c) != 6'd0) begin
            spec_flags |= flag_mask(c);
            scan_mode = M_FLG;
            return;
         end
         if (c == "*") begin
            spec_width_star = 1'b1;
            scan_mode = M_AFW;
            return;
         end
         if (c >= "1" && c <= "9") begin
            spec_width = {24'd0, c - 8'd48};
            scan_mode = M_WID;
            return;
         end
         m = M_AFW;
      end else if (m == M_WID) begin
         if (is_digit) begin
            if (!add_decimal(spec_width, {24'd0, c - 8'd48})) scan_mode = M_WOV;
            return;
         end
         m = M_AFW;
      end else if (m == M_WOV) begin
         if (!is_digit) spec_error(c);
         return;
      end
      if (m == M_AFW) begin
         if (c == ".") begin
            spec_prec_state = PS_GIVEN;
            spec_prec = '0;
            scan_mode = M_DOT;
            return;
         end
         m = M_LEN;
      end
      if (m == M_DOT) begin
         if (c == "*") begin
            spec_prec_state = PS_STAR;
            scan_mode = M_LEN;
            return;
         end
         m = M_PRC;
      end
      if (m == M_PRC && is_digit) begin
         if (spec_prec_state == PS_GIVEN && !add_decimal(spec_prec, {24'd0, c - 8'd48})) begin
            spec_prec_state = PS_OVF;
            spec_prec = '0;
         end
         scan_mode = M_PRC;
         return;
      end
      conversion_byte(c);
   endtask

   // Works out the tokens of one accepted byte and queues them.
   task automatic predict_tokens(input logic [7:0] c);
      step_count = 0;
      case (scan_mode)
         M_LIT: plain_byte(c);
         M_BSL: begin
            scan_mode = M_LIT;
            if (c == "$") add_token(KIND_LIT, "$", 2'd0);
            else begin
               add_token(KIND_LIT, "\\", 2'd0);
               plain_byte(c);
            end
         end
         M_DOL: dollar_byte(c);
         M_ERR: begin
            if (c == 8'h00) begin
               add_token(KIND_END, 8'h00, 2'd0);
               scan_mode = M_LIT;
            end
         end
         default: begin
            if (scan_mode >= M_PCT && scan_mode <= M_LEN) spec_char(c);
            else begin
               scan_mode = M_LIT;
               plain_byte(c);
            end
         end
      endcase
      if (step_count > 0) step_tokens[step_count-1].last = 1'b1;
      for (int i = 0; i < step_count; i++) expected_tokens.push_back(step_tokens[i]);
   endtask

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------

   // Offers one byte from the falling edge on and waits for its beat.
   task automatic send_byte(input logic [7:0] c);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            @(negedge clock);
            push <= 1'b0;
         end
      end
      @(negedge clock);
      push <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (full);
      predict_tokens(c);
      bytes_sent++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) fmt_bytes.push_back(s[i]);
   endtask

   task automatic send_buffer();
      while (fmt_bytes.size() > 0) send_byte(fmt_bytes.pop_front());
   endtask

   // Sends a string with its terminating zero byte.
   task automatic send_string(input string s);
      add_text(s);
      fmt_bytes.push_back(8'h00);
      send_buffer();
   endtask

   task automatic add_digits(input int n);
      fmt_bytes.push_back(8'(48 + $urandom_range(1, 9)));
      for (int i = 1; i < n; i++) fmt_bytes.push_back(8'(48 + $urandom_range(0, 9)));
   endtask

   // Appends one random conversion spec, mostly well formed.
   task automatic add_random_spec();
      string flag_chars;
      string lens[9];
      string convs;
      flag_chars = "#0- +'";
      lens = '{"", "l", "ll", "h", "hh", "L", "z", "t", "j"};
      convs = "diouxXeEfFgGaAcCsSpnm";
      fmt_bytes.push_back("%");
      repeat ($urandom_range(0, 3)) fmt_bytes.push_back(flag_chars[$urandom_range(0, 5)]);
      case ($urandom_range(0, 5))
         0, 1: ;
         2: fmt_bytes.push_back("*");
         3: add_text("2147483647");
         4: begin
            if ($urandom_range(0, 1)) add_text("2147483648");
            else add_text("99999999999");
         end
         default: add_digits($urandom_range(1, 5));
      endcase
      case ($urandom_range(0, 6))
         0, 1: ;
         2: fmt_bytes.push_back(".");
         3: add_text(".*");
         4: begin
            if ($urandom_range(0, 1)) add_text(".2147483647");
            else add_text(".2147483648");
         end
         5: add_text(".0");
         default: begin
            fmt_bytes.push_back(".");
            add_digits($urandom_range(1, 4));
         end
      endcase
      add_text(lens[$urandom_range(0, 8)]);
      if ($urandom_range(0, 9) == 0) fmt_bytes.push_back(8'($urandom_range(65, 122)));
      else fmt_bytes.push_back(convs[$urandom_range(0, convs.len() - 1)]);
   endtask

   // ------------------------------------------------------------------
   // Receiver: random pop with bursts of idle, and one long hold on request
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (hold_req) begin
         hold_cnt = 50;
         hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         hold_cnt = $urandom_range(0, 3);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // Each result beat is checked against the oldest expected token.
   always @(posedge clock) begin
      result_type exp_tok;
      if (!reset && pop && !empty) begin
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected result, kind %0d char %0d", $realtime, rsp_kind,
                     rsp_char_out);
            mismatch_count++;
         end else begin
            exp_tok = expected_tokens.pop_front();
            check_field("kind", exp_tok.kind, rsp_kind);
            check_field("char_out", exp_tok.char_out, rsp_char_out);
            check_field("directive", exp_tok.directive, rsp_directive);
            check_field("flag_bits", exp_tok.flag_bits, rsp_flag_bits);
            check_field("width", exp_tok.width, rsp_width);
            check_field("width_from_arg", exp_tok.width_from_arg, rsp_width_from_arg);
            check_field("precision", exp_tok.precision, rsp_precision);
            check_field("precision_mode", exp_tok.precision_mode, rsp_precision_mode);
            check_field("length_prefix", exp_tok.length_prefix, rsp_length_prefix);
            check_field("arg_class", exp_tok.arg_class, rsp_arg_class);
            check_field("last", exp_tok.last, rsp_last);
         end
      end
   end

   // Watchdog: too many cycles in a row without any beat ends the run.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $realtime);
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Byte extremes pass through as literals.
   task automatic test_literals();
      fmt_bytes.push_back(8'h01);
      fmt_bytes.push_back(8'hFF);
      add_text("A");
      fmt_bytes.push_back(8'h00);
      send_buffer();
   endtask

   // Percent and backslash escapes, all four directives and failed dollar sequences.
   task automatic test_escapes_and_directives();
      send_string("%%\\$\\q$fg$bg$sp$an$sq$$x");
   endtask

   // Full specs through every length state and the folded c and s.
   task automatic test_conversions();
      send_string("%#0- +'12.*lld%-0*.5hhn%Lf%zX%jo%tu%lc%ls%m%p%.d%hi");
   endtask

   // Width overflow, overflowed precision with and without a checked
   // conversion, a bad character with skipping, and a zero inside a spec.
   task automatic test_errors();
      send_string("%2147483648d");
      send_string("%.2147483648s%.99999999999d");
      send_string("%k ab%d");
      send_string("%5");
   endtask

   // The receiver holds off while bytes keep coming, so the queue fills.
   task automatic test_backpressure();
      hold_req = 1'b1;
      send_string("abcdefghijkl");
   endtask

   task automatic test_random();
      int goal;
      goal = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < goal) begin
         // Quiet traffic at the end of the run.
         if (bytes_sent > goal - 60) idle_on = 1'b0;
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(1, 6)) fmt_bytes.push_back(8'($urandom_range(0, 255)));
               send_buffer();
            end
            2: begin
               // A spec cut short by a random byte.
               add_random_spec();
               void'(fmt_bytes.pop_back());
               fmt_bytes.push_back(8'($urandom_range(0, 255)));
               fmt_bytes.push_back(8'h00);
               send_buffer();
            end
            default: begin
               repeat ($urandom_range(1, 3)) begin
                  case ($urandom_range(0, 5))
                     0: add_text("ab");
                     1: add_text("$fg");
                     2: add_text("\\$");
                     3: add_text("%%");
                     default: ;
                  endcase
                  add_random_spec();
               end
               fmt_bytes.push_back(8'h00);
               send_buffer();
            end
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_char_in = 8'h00;
      scan_mode = M_LIT;
      held_letter = 8'h00;
      held_count = 2'd0;
      clear_spec_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_literals();
      test_escapes_and_directives();
      test_conversions();
      test_errors();
      test_backpressure();
      test_random();

      @(negedge clock);
      push <= 1'b0;
      while (expected_tokens.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_tokens.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/fst_pkg.sv
rtl/core/fst_front.sv
rtl/core/fst_queue.sv
rtl/core/fst_back.sv
rtl/core/format_string_tokenizer_unit.sv
verif/tb_format_string_tokenizer_unit.sv
